@@ design/rbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants for the ring buffer deque
// Request and result payloads, action codes, controller states and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Action codes carried in the request; codes above POP_BACK act as peek
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_PEEK       = 3'd4;

  localparam int unsigned WordW = 32;
  localparam int unsigned OccW  = 8;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [WordW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] front_value;
    logic signed [WordW-1:0] back_value;
    logic                    is_empty;
    logic                    is_full;
    logic                    error;
    logic [OccW-1:0]         occupancy;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // take the request and update head, count and store
    logic read;  // fetch front and back words from the store
  } cmd_t;

endpackage

@@ design/rbd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ctrl: request sequencer
// Takes one request, lets the datapath update and read its store, then
// presents the result until the consumer takes it.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rbd_pkg::cmd_t cmd_o
);
  import rbd_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/rbd_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_dpath: deque datapath
// Holds head index, fill count and the circular word store; applies one
// action per load command and reads both ends on a read command.
// ----------------------------------------------------------------------------
module rbd_dpath #(
  parameter int unsigned DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbd_pkg::cmd_t      cmd_i,
  input  rbd_pkg::in_item_t  in_item_i,
  output rbd_pkg::out_item_t out_item_o
);
  import rbd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = $clog2(2 * DEPTH);

  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             err_q, err_d;
  logic             full, empty;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    head_dec, head_inc;
  logic [AW-1:0]    tail_addr, back_addr;
  logic [WordW-1:0] mem_q [DEPTH];
  logic [WordW-1:0] rd_front_q, rd_back_q;

  // Fold a sum below twice the depth back into the store
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
    logic [SW-1:0] res;
    res = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    return res[AW-1:0];
  endfunction

  assign full  = (cnt_q == CW'(DEPTH));
  assign empty = (cnt_q == '0);

  // Neighbor indexes around the current head and back
  assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign tail_addr = wrap(SW'(head_q) + SW'(cnt_q));
  assign back_addr = wrap(SW'(head_q) + SW'(cnt_q) - SW'(1));

  // Apply the requested action
  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    err_d   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = tail_addr;
    case (in_item_i.action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          err_d = 1'b1;
        end else begin
          head_d  = head_dec;
          wr_addr = head_dec;
          wr_en   = 1'b1;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          err_d = 1'b1;
        end else begin
          wr_addr = tail_addr;
          wr_en   = 1'b1;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          err_d = 1'b1;
        end else begin
          head_d = head_inc;
          cnt_d  = cnt_q - CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          err_d = 1'b1;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state: advance only on a load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      err_q  <= 1'b0;
    end else if (cmd_i.load) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
    end
  end

  // Store write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_en) begin
      mem_q[wr_addr] <= in_item_i.value;
    end
  end

  // Store read ports, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_front_q <= mem_q[head_q];
      rd_back_q  <= mem_q[back_addr];
    end
  end

  // Build the result; drop stale words when empty
  always_comb begin
    out_item_o.front_value = empty ? '1 : rd_front_q;
    out_item_o.back_value  = empty ? '1 : rd_back_q;
    out_item_o.is_empty    = empty;
    out_item_o.is_full     = full;
    out_item_o.error       = err_q;
    out_item_o.occupancy   = OccW'(cnt_q);
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(DEPTH - 1))
    else $error("head index outside store");

  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && err_d |=> cnt_q == $past(cnt_q) && head_q == $past(head_q))
    else $error("failed request changed the deque");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load |=> $stable(cnt_q) && $stable(head_q))
    else $error("deque state moved without a request");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && cmd_i.read))
    else $error("load and read issued together");
`endif

endmodule

@@ design/ring_buffer_deque.sv @@
`timescale 1ns / 1ps
// Sequence: a request is loaded on acceptance, the word store is read in
// the read state, and the result is then presented in the send state.
// Flow: no new request is taken until the current result is taken, since
// the sequencer holds one request at a time and reads the word store
// through registers.
// Reset: head index and count clear to zero at once; store contents stay
// undefined until written and are never shown while the deque is empty.
// ----------------------------------------------------------------------------
// ring_buffer_deque: double-ended queue in a circular word store
// Push or pop at either end, or peek; reports both ends, flags and count.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
  parameter int unsigned DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rbd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rbd_pkg::out_item_t out_item_o
);
  import rbd_pkg::*;

  cmd_t cmd;

  // Sequencer
  rbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Head, count and store
  rbd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ tb/tb_ring_buffer_deque.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque: self-checking bench for the ring buffer deque
// Drives push, pop and peek requests at both ends. A scoreboard model of the
// circular store tracks head and count and predicts every result. The run
// covers errors on an empty store, errors on a full store, index wrap at both
// ends, unused action codes, and random traffic under sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque;
  import rbd_pkg::*;

  localparam int unsigned Depth        = 128;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxReports   = 40;
  // Highest action code; everything above ACT_PEEK behaves as a peek
  localparam logic [2:0]  ActLast      = 3'd7;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  // Scoreboard copy of the deque
  logic [WordW-1:0] deque_slots [Depth];
  int unsigned      deque_head  = 0;
  int unsigned      deque_count = 0;
  out_item_t        expected_views [$];

  ring_buffer_deque #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Apply one action to the scoreboard deque and return the view it leaves
  function automatic out_item_t apply_action(in_item_t req);
    out_item_t view;
    logic      fault;
    fault = 1'b0;
    case (req.action)
      ACT_PUSH_FRONT: begin
        if (deque_count == Depth) begin
          fault = 1'b1;
        end else begin
          deque_head = (deque_head + Depth - 1) % Depth;
          deque_slots[deque_head] = req.value;
          deque_count++;
        end
      end
      ACT_PUSH_BACK: begin
        if (deque_count == Depth) begin
          fault = 1'b1;
        end else begin
          deque_slots[(deque_head + deque_count) % Depth] = req.value;
          deque_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (deque_count == 0) begin
          fault = 1'b1;
        end else begin
          deque_head = (deque_head + 1) % Depth;
          deque_count--;
        end
      end
      ACT_POP_BACK: begin
        if (deque_count == 0) begin
          fault = 1'b1;
        end else begin
          deque_count--;
        end
      end
      default: ;
    endcase
    view.front_value = '1;
    view.back_value  = '1;
    if (deque_count != 0) begin
      view.front_value = deque_slots[deque_head];
      view.back_value  = deque_slots[(deque_head + deque_count - 1) % Depth];
    end
    view.is_empty  = (deque_count == 0);
    view.is_full   = (deque_count == Depth);
    view.error     = fault;
    view.occupancy = deque_count[OccW-1:0];
    return view;
  endfunction

  // Random data word, leaning on the extremes now and then
  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  // Present one request, hold it until accepted, then log its prediction
  task automatic send_request(logic [2:0] action, logic [WordW-1:0] value);
    in_item_t req;
    req.action = action;
    req.value  = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_views.push_back(apply_action(req));
    @(negedge clk_i);
  endtask

  // Randomize the result stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_views.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_views.pop_front();
        if (out_item_o.front_value !== want.front_value) begin
          report_mismatch($sformatf("front_value got %0d want %0d",
                                    out_item_o.front_value, want.front_value));
        end
        if (out_item_o.back_value !== want.back_value) begin
          report_mismatch($sformatf("back_value got %0d want %0d",
                                    out_item_o.back_value, want.back_value));
        end
        if (out_item_o.is_empty !== want.is_empty) begin
          report_mismatch($sformatf("is_empty got %b want %b",
                                    out_item_o.is_empty, want.is_empty));
        end
        if (out_item_o.is_full !== want.is_full) begin
          report_mismatch($sformatf("is_full got %b want %b",
                                    out_item_o.is_full, want.is_full));
        end
        if (out_item_o.error !== want.error) begin
          report_mismatch($sformatf("error got %b want %b",
                                    out_item_o.error, want.error));
        end
        if (out_item_o.occupancy !== want.occupancy) begin
          report_mismatch($sformatf("occupancy got %0d want %0d",
                                    out_item_o.occupancy, want.occupancy));
        end
      end
    end
  end

  // Pops on an empty store, peek, and the unused action codes
  task automatic test_empty_and_peek();
    send_request(ACT_POP_FRONT, pick_word());
    send_request(ACT_POP_BACK, pick_word());
    send_request(ACT_PEEK, pick_word());
    for (int a = ACT_PEEK + 1; a <= ActLast; a++) begin
      send_request(a[2:0], pick_word());
    end
  endtask

  // Extreme words at both ends, head wrap below zero, pop down to empty
  task automatic test_ends_and_extremes();
    send_request(ACT_PUSH_FRONT, 32'h8000_0000);
    send_request(ACT_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(ACT_PUSH_BACK, 32'h0000_0000);
    send_request(ACT_PEEK, pick_word());
    send_request(ACT_POP_BACK, pick_word());
    send_request(ACT_POP_FRONT, pick_word());
    send_request(ACT_POP_FRONT, pick_word());
    // last element leaves; head stays where it is
    send_request(ACT_POP_BACK, pick_word());
    send_request(ACT_POP_FRONT, pick_word());
    send_request(ACT_PUSH_BACK, 32'h5A5A_A5A5);
    send_request(ACT_POP_FRONT, pick_word());
  endtask

  // Fill to capacity from both ends, push into a full store, drain again
  task automatic test_full_store();
    while (deque_count < Depth) begin
      send_request($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_word());
    end
    send_request(ACT_PUSH_FRONT, pick_word());
    send_request(ACT_PUSH_BACK, pick_word());
    send_request(ACT_PEEK, pick_word());
    while (deque_count != 0) begin
      send_request($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, pick_word());
    end
    send_request(ACT_POP_BACK, pick_word());
  endtask

  // Random traffic in segments that drift toward full or toward empty
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned seg_left;
    int unsigned push_pct;
    int unsigned roll;
    logic [2:0]  action;
    seg_left = 0;
    push_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(160, 16);
        push_pct = $urandom_range(1) ? 75 : 30;
      end
      seg_left--;
      roll = $urandom_range(99);
      if (roll < 6) begin
        action = 3'($urandom_range(ActLast, ACT_PEEK));
      end else if (roll < push_pct) begin
        action = 3'($urandom_range(ACT_PUSH_BACK, ACT_PUSH_FRONT));
      end else begin
        action = 3'($urandom_range(ACT_POP_BACK, ACT_POP_FRONT));
      end
      send_request(action, pick_word());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_and_peek();
    test_ends_and_extremes();
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    test_full_store();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(200);
    send_idle_pct  = 77;
    recv_stall_pct = 0;
    test_random_traffic(200);
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    test_random_traffic(200);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    test_random_traffic(200);

    // Drain outstanding results, then watch for strays
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ring_buffer_deque] OK");
    end else begin
      $display("[ring_buffer_deque] ERROR");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("[ring_buffer_deque] ERROR");
    $finish;
  end

endmodule
